[hdl/mvt_pkg.sv]
// Shared types, constants and the solve program for the triangulation block.
`default_nettype none
package mvt_pkg;

    localparam int CAMERAS_DEF = 8;
    localparam int COEFS = 12;
    localparam int QDEPTH = 2;
    localparam int STEPS = 24;
    localparam logic [11:0] FOCAL_RESET = 12'd1;
    localparam logic [3:0] VIEW_MAX = 4'd15;
    localparam logic [3:0] VIEW_MIN = 4'd2;
    localparam logic [3:0] PAIR_LAST = 4'd8;
    localparam logic [3:0] PAIR_RHS = 4'd6;
    localparam logic [4:0] STEP_LAST = 5'(STEPS - 1);

    typedef enum logic [1:0] {
        K_WRITE,
        K_OBS,
        K_SOLVE
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [2:0]         camera;
        logic [3:0]         coef_index;
        logic signed [47:0] coef_value;
        logic [19:0]        obs_x;
        logic [19:0]        obs_y;
        logic               last_obs;
    } qword_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD2,
        ST_RD1,
        ST_C1,
        ST_C2,
        ST_T,
        ST_PMUL,
        ST_PWAIT,
        ST_PSAT,
        ST_PACC,
        ST_CHK,
        ST_FIT,
        ST_SMUL,
        ST_SWAIT,
        ST_DCHK,
        ST_DWAIT,
        ST_EMIT
    } back_state_t;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_RUN,
        MUL_FIX
    } mul_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_PREP,
        DIV_RUN,
        DIV_FIX
    } div_state_t;

    typedef enum logic [3:0] {
        OP_A, OP_B, OP_C, OP_D, OP_E, OP_F, OP_G, OP_H, OP_I,
        OP_C00, OP_C01, OP_C02, OP_C11, OP_C12, OP_C22
    } op_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_C00, DST_C01, DST_C02, DST_C11, DST_C12, DST_C22,
        DST_DET,
        DST_NUM
    } dst_t;

    typedef struct packed {
        op_t  a;
        op_t  b;
        logic neg;
        logic first;
        dst_t dst;
    } step_t;

    typedef struct packed {
        logic [1:0] ia;
        logic [1:0] ib;
    } pair_t;

    function automatic pair_t mvt_pair(input logic [3:0] pk);
        pair_t p;
        unique case (pk)
            4'd0:    p = '{ia: 2'd0, ib: 2'd0};
            4'd1:    p = '{ia: 2'd0, ib: 2'd1};
            4'd2:    p = '{ia: 2'd0, ib: 2'd2};
            4'd3:    p = '{ia: 2'd1, ib: 2'd1};
            4'd4:    p = '{ia: 2'd1, ib: 2'd2};
            4'd5:    p = '{ia: 2'd2, ib: 2'd2};
            4'd6:    p = '{ia: 2'd0, ib: 2'd3};
            4'd7:    p = '{ia: 2'd1, ib: 2'd3};
            4'd8:    p = '{ia: 2'd2, ib: 2'd3};
            default: p = '{ia: 2'd0, ib: 2'd0};
        endcase
        return p;
    endfunction

    function automatic step_t mvt_step(input logic [4:0] k);
        step_t s;
        unique case (k)
            5'd0:    s = '{a: OP_D,   b: OP_F,   neg: 1'b0, first: 1'b1, dst: DST_NONE};
            5'd1:    s = '{a: OP_E,   b: OP_E,   neg: 1'b1, first: 1'b0, dst: DST_C00};
            5'd2:    s = '{a: OP_C,   b: OP_E,   neg: 1'b0, first: 1'b1, dst: DST_NONE};
            5'd3:    s = '{a: OP_B,   b: OP_F,   neg: 1'b1, first: 1'b0, dst: DST_C01};
            5'd4:    s = '{a: OP_B,   b: OP_E,   neg: 1'b0, first: 1'b1, dst: DST_NONE};
            5'd5:    s = '{a: OP_D,   b: OP_C,   neg: 1'b1, first: 1'b0, dst: DST_C02};
            5'd6:    s = '{a: OP_A,   b: OP_F,   neg: 1'b0, first: 1'b1, dst: DST_NONE};
            5'd7:    s = '{a: OP_C,   b: OP_C,   neg: 1'b1, first: 1'b0, dst: DST_C11};
            5'd8:    s = '{a: OP_B,   b: OP_C,   neg: 1'b0, first: 1'b1, dst: DST_NONE};
            5'd9:    s = '{a: OP_A,   b: OP_E,   neg: 1'b1, first: 1'b0, dst: DST_C12};
            5'd10:   s = '{a: OP_A,   b: OP_D,   neg: 1'b0, first: 1'b1, dst: DST_NONE};
            5'd11:   s = '{a: OP_B,   b: OP_B,   neg: 1'b1, first: 1'b0, dst: DST_C22};
            5'd12:   s = '{a: OP_A,   b: OP_C00, neg: 1'b0, first: 1'b1, dst: DST_NONE};
            5'd13:   s = '{a: OP_B,   b: OP_C01, neg: 1'b0, first: 1'b0, dst: DST_NONE};
            5'd14:   s = '{a: OP_C,   b: OP_C02, neg: 1'b0, first: 1'b0, dst: DST_DET};
            5'd15:   s = '{a: OP_C00, b: OP_G,   neg: 1'b0, first: 1'b1, dst: DST_NONE};
            5'd16:   s = '{a: OP_C01, b: OP_H,   neg: 1'b0, first: 1'b0, dst: DST_NONE};
            5'd17:   s = '{a: OP_C02, b: OP_I,   neg: 1'b0, first: 1'b0, dst: DST_NUM};
            5'd18:   s = '{a: OP_C01, b: OP_G,   neg: 1'b0, first: 1'b1, dst: DST_NONE};
            5'd19:   s = '{a: OP_C11, b: OP_H,   neg: 1'b0, first: 1'b0, dst: DST_NONE};
            5'd20:   s = '{a: OP_C12, b: OP_I,   neg: 1'b0, first: 1'b0, dst: DST_NUM};
            5'd21:   s = '{a: OP_C02, b: OP_G,   neg: 1'b0, first: 1'b1, dst: DST_NONE};
            5'd22:   s = '{a: OP_C12, b: OP_H,   neg: 1'b0, first: 1'b0, dst: DST_NONE};
            5'd23:   s = '{a: OP_C22, b: OP_I,   neg: 1'b0, first: 1'b0, dst: DST_NUM};
            default: s = '{a: OP_A,   b: OP_A,   neg: 1'b0, first: 1'b1, dst: DST_NONE};
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

[hdl/mvt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mvt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 96
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[hdl/mvt_mul.sv]
// Signed 64x64 multiplier built from one 32x32 partial product per cycle.
`default_nettype none
module mvt_mul (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic signed [63:0]  a,
    input  wire logic signed [63:0]  b,
    output logic                     done,
    output logic signed [127:0]      p
);

    mvt_pkg::mul_state_t state_reg, state_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         done_reg, done_next;
    logic [63:0]  am_reg, bm_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic signed [127:0] p_reg;
    logic [31:0]  a_half, b_half;
    logic [63:0]  part;
    logic [127:0] part_sh;

    assign a_half = cnt_reg[1] ? am_reg[63:32] : am_reg[31:0];
    assign b_half = cnt_reg[0] ? bm_reg[63:32] : bm_reg[31:0];
    assign part = a_half * b_half;

    always_comb
    begin
        unique case ({cnt_reg[1], cnt_reg[0]})
            2'b00:   part_sh = {64'd0, part};
            2'b11:   part_sh = {part, 64'd0};
            default: part_sh = {32'd0, part, 32'd0};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        unique case (state_reg)
            mvt_pkg::MUL_IDLE:
            begin
                if (start)
                begin
                    cnt_next = 2'd0;
                    state_next = mvt_pkg::MUL_RUN;
                end
            end
            mvt_pkg::MUL_RUN:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = mvt_pkg::MUL_FIX;
                end
            end
            mvt_pkg::MUL_FIX:
            begin
                done_next = 1'b1;
                state_next = mvt_pkg::MUL_IDLE;
            end
            default: state_next = mvt_pkg::MUL_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mvt_pkg::MUL_IDLE;
            cnt_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mvt_pkg::MUL_IDLE && start)
        begin
            am_reg <= a[63] ? 64'd0 - a : a;
            bm_reg <= b[63] ? 64'd0 - b : b;
            neg_reg <= a[63] ^ b[63];
            acc_reg <= 128'd0;
        end
        else if (state_reg == mvt_pkg::MUL_RUN)
        begin
            acc_reg <= acc_reg + part_sh;
        end
        if (state_reg == mvt_pkg::MUL_FIX)
        begin
            p_reg <= neg_reg ? $signed(128'd0 - acc_reg) : $signed(acc_reg);
        end
    end

    assign done = done_reg;
    assign p = p_reg;

endmodule
`default_nettype wire

[hdl/mvt_div.sv]
// Restoring divider giving round(num * 2^16 / den), saturated to 48 bits.
`default_nettype none
module mvt_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic signed [127:0] num,
    input  wire logic signed [127:0] den,
    output logic                     done,
    output logic signed [47:0]       q
);

    localparam logic [127:0] POS_LIMIT = 128'h7FFF_FFFF_FFFF;
    localparam logic [127:0] NEG_LIMIT = 128'h8000_0000_0000;

    mvt_pkg::div_state_t state_reg, state_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic         done_reg, done_next;
    logic signed [127:0] num_reg, den_reg;
    logic [127:0] nmag, dmag;
    logic [127:0] n_reg, d_reg, r_reg, quo_reg;
    logic         neg_reg;
    logic [127:0] r_sh;
    logic         ge;
    logic [127:0] limit, sat;
    logic signed [47:0] q_reg;

    assign nmag = num_reg[127] ? 128'd0 - num_reg : num_reg;
    assign dmag = den_reg[127] ? 128'd0 - den_reg : den_reg;
    assign r_sh = {r_reg[126:0], n_reg[127]};
    assign ge = r_sh >= d_reg;
    assign limit = neg_reg ? NEG_LIMIT : POS_LIMIT;
    assign sat = (quo_reg > limit) ? limit : quo_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        unique case (state_reg)
            mvt_pkg::DIV_IDLE:
            begin
                if (start)
                begin
                    state_next = mvt_pkg::DIV_PREP;
                end
            end
            mvt_pkg::DIV_PREP:
            begin
                cnt_next = 7'd127;
                state_next = mvt_pkg::DIV_RUN;
            end
            mvt_pkg::DIV_RUN:
            begin
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    state_next = mvt_pkg::DIV_FIX;
                end
            end
            mvt_pkg::DIV_FIX:
            begin
                done_next = 1'b1;
                state_next = mvt_pkg::DIV_IDLE;
            end
            default: state_next = mvt_pkg::DIV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mvt_pkg::DIV_IDLE;
            cnt_reg <= 7'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            mvt_pkg::DIV_IDLE:
            begin
                if (start)
                begin
                    num_reg <= num;
                    den_reg <= den;
                end
            end
            mvt_pkg::DIV_PREP:
            begin
                n_reg <= (nmag << 17) + dmag;
                d_reg <= dmag << 1;
                r_reg <= 128'd0;
                quo_reg <= 128'd0;
                neg_reg <= num_reg[127] ^ den_reg[127];
            end
            mvt_pkg::DIV_RUN:
            begin
                r_reg <= ge ? r_sh - d_reg : r_sh;
                quo_reg <= {quo_reg[126:0], ge};
                n_reg <= n_reg << 1;
            end
            mvt_pkg::DIV_FIX:
            begin
                q_reg <= neg_reg ? $signed(48'd0 - sat[47:0]) : $signed(sat[47:0]);
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign q = q_reg;

endmodule
`default_nettype wire

[hdl/mvt_front.sv]
// Front end: accept and classify commands, hold them in a short queue.
`default_nettype none
module mvt_front #(
    parameter int CAMERAS = mvt_pkg::CAMERAS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               cmd,
    input  wire logic [2:0]         camera,
    input  wire logic [3:0]         coef_index,
    input  wire logic signed [47:0] coef_value,
    input  wire logic [19:0]        obs_x,
    input  wire logic [19:0]        obs_y,
    input  wire logic               last_obs,
    output logic                    busy,
    output mvt_pkg::qword_t         q_word,
    output logic                    q_valid,
    input  wire logic               q_pop
);

    localparam int PW = (mvt_pkg::QDEPTH > 1) ? $clog2(mvt_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(mvt_pkg::QDEPTH + 1);

    mvt_pkg::qword_t entry_reg [mvt_pkg::QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          cam_ok, idx_ok, keep, push, pop;
    mvt_pkg::qword_t word;

    assign cam_ok = 32'(camera) < CAMERAS;
    assign idx_ok = 32'(coef_index) < mvt_pkg::COEFS;

    always_comb
    begin
        word.camera = camera;
        word.coef_index = coef_index;
        word.coef_value = coef_value;
        word.obs_x = obs_x;
        word.obs_y = obs_y;
        word.last_obs = last_obs;
        priority if (!cmd)
        begin
            word.kind = mvt_pkg::K_WRITE;
            keep = cam_ok && idx_ok;
        end
        else if (cam_ok)
        begin
            word.kind = mvt_pkg::K_OBS;
            keep = 1'b1;
        end
        else
        begin
            word.kind = mvt_pkg::K_SOLVE;
            keep = last_obs;
        end
    end

    assign busy = count_reg == CW'(mvt_pkg::QDEPTH);
    assign push = start && !busy && keep;
    assign pop = q_pop && q_valid;
    assign q_valid = count_reg != '0;
    assign q_word = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == mvt_pkg::QDEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == mvt_pkg::QDEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= word;
        end
    end

endmodule
`default_nettype wire

[hdl/mvt_back.sv]
// Back end: coefficient store, normal-equation accumulation and Cramer solve.
`default_nettype none
module mvt_back #(
    parameter int CAMERAS = mvt_pkg::CAMERAS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [11:0]        focal_scale,
    input  mvt_pkg::qword_t         q_word,
    input  wire logic               q_valid,
    output logic                    q_pop,
    output logic signed [47:0]      pos_x,
    output logic signed [47:0]      pos_y,
    output logic signed [47:0]      pos_z,
    output logic                    singular,
    output logic                    done
);

    localparam int DEPTH = CAMERAS * mvt_pkg::COEFS;
    localparam int AW = $clog2(DEPTH);
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    mvt_pkg::back_state_t state_reg, state_next;
    mvt_pkg::qword_t word_reg;
    logic [1:0]  j_reg;
    logic        r_reg;
    logic [3:0]  pk_reg;
    logic [4:0]  k_reg;
    logic [1:0]  n_reg;
    logic [3:0]  view_reg;
    logic        sing_reg;
    logic        done_reg, done_next;
    logic signed [63:0] acc_reg [9];
    logic signed [63:0] v_reg [9];
    logic signed [63:0] cof_reg [6];
    logic signed [63:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic signed [47:0] pos_reg [3];
    logic [47:0] p2_reg;
    logic signed [47:0] pr_reg;
    logic signed [44:0] hiw_reg;
    logic signed [63:0] c_reg;
    logic signed [127:0] prod_reg;
    logic signed [63:0] q_reg;
    logic signed [127:0] sacc_reg, sacc_new, det_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [47:0]   ram_rdata;

    logic               mul_start, mul_done;
    logic signed [63:0] mul_a, mul_b, op_a, op_b, ta, tb;
    logic signed [127:0] mul_p;
    logic               div_start, div_done;
    logic signed [47:0] div_q;

    mvt_pkg::step_t step;
    mvt_pkg::pair_t pair;
    logic [19:0]        w_sel;
    logic signed [44:0] hiw_next;
    logic [43:0]        lo_prod;
    logic signed [63:0] fs_ext, pr_ext, fp;
    logic               fits, prod_ok;
    logic signed [64:0] acc_sum;
    logic signed [63:0] acc_sat;

    assign step = mvt_pkg::mvt_step(k_reg);
    assign pair = mvt_pkg::mvt_pair(pk_reg);

    mvt_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_word.coef_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mvt_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    mvt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sacc_new),
        .den   (det_reg),
        .done  (div_done),
        .q     (div_q)
    );

    assign ram_waddr = AW'(32'(q_word.camera) * mvt_pkg::COEFS + 32'(q_word.coef_index));
    assign ram_raddr = (state_reg == mvt_pkg::ST_RD2)
        ? AW'(32'(word_reg.camera) * mvt_pkg::COEFS + 8 + 32'(j_reg))
        : AW'(32'(word_reg.camera) * mvt_pkg::COEFS + 4 * 32'(r_reg) + 32'(j_reg));

    assign w_sel = r_reg ? word_reg.obs_y : word_reg.obs_x;
    assign hiw_next = $signed(p2_reg[47:24]) * $signed({1'b0, w_sel});
    assign lo_prod = p2_reg[23:0] * w_sel;
    assign fs_ext = 64'($signed({1'b0, focal_scale}));
    assign pr_ext = 64'(pr_reg);
    assign fp = fs_ext * pr_ext;

    always_comb
    begin
        unique case (pair.ia)
            2'd0: ta = t0_reg;
            2'd1: ta = t1_reg;
            2'd2: ta = t2_reg;
            2'd3: ta = t3_reg;
        endcase
        unique case (pair.ib)
            2'd0: tb = t0_reg;
            2'd1: tb = t1_reg;
            2'd2: tb = t2_reg;
            2'd3: tb = t3_reg;
        endcase
    end

    always_comb
    begin
        unique case (step.a)
            mvt_pkg::OP_A:   op_a = v_reg[0];
            mvt_pkg::OP_B:   op_a = v_reg[1];
            mvt_pkg::OP_C:   op_a = v_reg[2];
            mvt_pkg::OP_D:   op_a = v_reg[3];
            mvt_pkg::OP_E:   op_a = v_reg[4];
            mvt_pkg::OP_F:   op_a = v_reg[5];
            mvt_pkg::OP_G:   op_a = v_reg[6];
            mvt_pkg::OP_H:   op_a = v_reg[7];
            mvt_pkg::OP_I:   op_a = v_reg[8];
            mvt_pkg::OP_C00: op_a = cof_reg[0];
            mvt_pkg::OP_C01: op_a = cof_reg[1];
            mvt_pkg::OP_C02: op_a = cof_reg[2];
            mvt_pkg::OP_C11: op_a = cof_reg[3];
            mvt_pkg::OP_C12: op_a = cof_reg[4];
            mvt_pkg::OP_C22: op_a = cof_reg[5];
            default:         op_a = '0;
        endcase
        unique case (step.b)
            mvt_pkg::OP_A:   op_b = v_reg[0];
            mvt_pkg::OP_B:   op_b = v_reg[1];
            mvt_pkg::OP_C:   op_b = v_reg[2];
            mvt_pkg::OP_D:   op_b = v_reg[3];
            mvt_pkg::OP_E:   op_b = v_reg[4];
            mvt_pkg::OP_F:   op_b = v_reg[5];
            mvt_pkg::OP_G:   op_b = v_reg[6];
            mvt_pkg::OP_H:   op_b = v_reg[7];
            mvt_pkg::OP_I:   op_b = v_reg[8];
            mvt_pkg::OP_C00: op_b = cof_reg[0];
            mvt_pkg::OP_C01: op_b = cof_reg[1];
            mvt_pkg::OP_C02: op_b = cof_reg[2];
            mvt_pkg::OP_C11: op_b = cof_reg[3];
            mvt_pkg::OP_C12: op_b = cof_reg[4];
            mvt_pkg::OP_C22: op_b = cof_reg[5];
            default:         op_b = '0;
        endcase
    end

    assign mul_a = (state_reg == mvt_pkg::ST_PMUL) ? ta : op_a;
    assign mul_b = (state_reg == mvt_pkg::ST_PMUL) ? tb : op_b;

    always_comb
    begin
        fits = 1'b1;
        for (int i = 0; i < 9; i++)
        begin
            if (!((&v_reg[i][63:30]) || !(|v_reg[i][63:30])))
            begin
                fits = 1'b0;
            end
        end
    end

    assign prod_ok = (&prod_reg[127:95]) || !(|prod_reg[127:95]);
    assign acc_sum = (pk_reg < mvt_pkg::PAIR_RHS)
        ? 65'(acc_reg[pk_reg]) + 65'(q_reg)
        : 65'(acc_reg[pk_reg]) - 65'(q_reg);
    assign acc_sat = (acc_sum[64] != acc_sum[63])
        ? (acc_sum[64] ? S64_MIN : S64_MAX) : acc_sum[63:0];

    always_comb
    begin
        if (step.first)
        begin
            sacc_new = step.neg ? -mul_p : mul_p;
        end
        else
        begin
            sacc_new = step.neg ? sacc_reg - mul_p : sacc_reg + mul_p;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop = 1'b0;
        ram_we = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        done_next = 1'b0;
        unique case (state_reg)
            mvt_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_word.kind)
                        mvt_pkg::K_WRITE: ram_we = 1'b1;
                        mvt_pkg::K_OBS:   state_next = mvt_pkg::ST_RD2;
                        mvt_pkg::K_SOLVE: state_next = mvt_pkg::ST_CHK;
                        default:          state_next = mvt_pkg::ST_IDLE;
                    endcase
                end
            end
            mvt_pkg::ST_RD2: state_next = mvt_pkg::ST_RD1;
            mvt_pkg::ST_RD1: state_next = mvt_pkg::ST_C1;
            mvt_pkg::ST_C1:  state_next = mvt_pkg::ST_C2;
            mvt_pkg::ST_C2:  state_next = mvt_pkg::ST_T;
            mvt_pkg::ST_T:
            begin
                state_next = (j_reg == 2'd3) ? mvt_pkg::ST_PMUL : mvt_pkg::ST_RD2;
            end
            mvt_pkg::ST_PMUL:
            begin
                mul_start = 1'b1;
                state_next = mvt_pkg::ST_PWAIT;
            end
            mvt_pkg::ST_PWAIT:
            begin
                if (mul_done)
                begin
                    state_next = mvt_pkg::ST_PSAT;
                end
            end
            mvt_pkg::ST_PSAT: state_next = mvt_pkg::ST_PACC;
            mvt_pkg::ST_PACC:
            begin
                priority if (pk_reg != mvt_pkg::PAIR_LAST)
                begin
                    state_next = mvt_pkg::ST_PMUL;
                end
                else if (!r_reg)
                begin
                    state_next = mvt_pkg::ST_RD2;
                end
                else if (word_reg.last_obs)
                begin
                    state_next = mvt_pkg::ST_CHK;
                end
                else
                begin
                    state_next = mvt_pkg::ST_IDLE;
                end
            end
            mvt_pkg::ST_CHK:
            begin
                state_next = (view_reg < mvt_pkg::VIEW_MIN) ? mvt_pkg::ST_EMIT : mvt_pkg::ST_FIT;
            end
            mvt_pkg::ST_FIT:
            begin
                if (fits)
                begin
                    state_next = mvt_pkg::ST_SMUL;
                end
            end
            mvt_pkg::ST_SMUL:
            begin
                mul_start = 1'b1;
                state_next = mvt_pkg::ST_SWAIT;
            end
            mvt_pkg::ST_SWAIT:
            begin
                if (mul_done)
                begin
                    priority if (step.dst == mvt_pkg::DST_DET)
                    begin
                        state_next = mvt_pkg::ST_DCHK;
                    end
                    else if (step.dst == mvt_pkg::DST_NUM)
                    begin
                        div_start = 1'b1;
                        state_next = mvt_pkg::ST_DWAIT;
                    end
                    else
                    begin
                        state_next = mvt_pkg::ST_SMUL;
                    end
                end
            end
            mvt_pkg::ST_DCHK:
            begin
                state_next = (det_reg == '0) ? mvt_pkg::ST_EMIT : mvt_pkg::ST_SMUL;
            end
            mvt_pkg::ST_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = (n_reg == 2'd2) ? mvt_pkg::ST_EMIT : mvt_pkg::ST_SMUL;
                end
            end
            mvt_pkg::ST_EMIT:
            begin
                done_next = 1'b1;
                state_next = mvt_pkg::ST_IDLE;
            end
            default: state_next = mvt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mvt_pkg::ST_IDLE;
            done_reg <= 1'b0;
            view_reg <= 4'd0;
            sing_reg <= 1'b0;
            j_reg <= 2'd0;
            r_reg <= 1'b0;
            pk_reg <= 4'd0;
            k_reg <= 5'd0;
            n_reg <= 2'd0;
            for (int i = 0; i < 9; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
            unique case (state_reg)
                mvt_pkg::ST_IDLE:
                begin
                    j_reg <= 2'd0;
                    r_reg <= 1'b0;
                    pk_reg <= 4'd0;
                end
                mvt_pkg::ST_T:
                begin
                    j_reg <= j_reg + 2'd1;
                end
                mvt_pkg::ST_PACC:
                begin
                    acc_reg[pk_reg] <= acc_sat;
                    if (pk_reg == mvt_pkg::PAIR_LAST)
                    begin
                        pk_reg <= 4'd0;
                        r_reg <= !r_reg;
                        if (r_reg && view_reg != mvt_pkg::VIEW_MAX)
                        begin
                            view_reg <= view_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        pk_reg <= pk_reg + 4'd1;
                    end
                end
                mvt_pkg::ST_CHK:
                begin
                    sing_reg <= view_reg < mvt_pkg::VIEW_MIN;
                    k_reg <= 5'd0;
                    n_reg <= 2'd0;
                end
                mvt_pkg::ST_SWAIT:
                begin
                    if (mul_done && k_reg != mvt_pkg::STEP_LAST)
                    begin
                        k_reg <= k_reg + 5'd1;
                    end
                end
                mvt_pkg::ST_DCHK:
                begin
                    sing_reg <= det_reg == '0;
                end
                mvt_pkg::ST_DWAIT:
                begin
                    if (div_done)
                    begin
                        n_reg <= n_reg + 2'd1;
                    end
                end
                mvt_pkg::ST_EMIT:
                begin
                    view_reg <= 4'd0;
                    for (int i = 0; i < 9; i++)
                    begin
                        acc_reg[i] <= '0;
                    end
                end
                default:
                begin
                    sing_reg <= sing_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            mvt_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    word_reg <= q_word;
                end
            end
            mvt_pkg::ST_RD1:
            begin
                p2_reg <= ram_rdata;
            end
            mvt_pkg::ST_C1:
            begin
                pr_reg <= $signed(ram_rdata);
                hiw_reg <= hiw_next;
            end
            mvt_pkg::ST_C2:
            begin
                c_reg <= (64'(hiw_reg) <<< 16) + $signed({28'd0, lo_prod[43:8]});
            end
            mvt_pkg::ST_T:
            begin
                unique case (j_reg)
                    2'd0: t0_reg <= fp - c_reg;
                    2'd1: t1_reg <= fp - c_reg;
                    2'd2: t2_reg <= fp - c_reg;
                    2'd3: t3_reg <= fp - c_reg;
                endcase
            end
            mvt_pkg::ST_PWAIT:
            begin
                if (mul_done)
                begin
                    prod_reg <= mul_p;
                end
            end
            mvt_pkg::ST_PSAT:
            begin
                q_reg <= prod_ok ? prod_reg[95:32] : (prod_reg[127] ? S64_MIN : S64_MAX);
            end
            mvt_pkg::ST_CHK:
            begin
                for (int i = 0; i < 9; i++)
                begin
                    v_reg[i] <= acc_reg[i];
                end
            end
            mvt_pkg::ST_FIT:
            begin
                if (!fits)
                begin
                    for (int i = 0; i < 9; i++)
                    begin
                        v_reg[i] <= v_reg[i] >>> 1;
                    end
                end
            end
            mvt_pkg::ST_SWAIT:
            begin
                if (mul_done)
                begin
                    sacc_reg <= sacc_new;
                    unique case (step.dst)
                        mvt_pkg::DST_C00: cof_reg[0] <= sacc_new[63:0];
                        mvt_pkg::DST_C01: cof_reg[1] <= sacc_new[63:0];
                        mvt_pkg::DST_C02: cof_reg[2] <= sacc_new[63:0];
                        mvt_pkg::DST_C11: cof_reg[3] <= sacc_new[63:0];
                        mvt_pkg::DST_C12: cof_reg[4] <= sacc_new[63:0];
                        mvt_pkg::DST_C22: cof_reg[5] <= sacc_new[63:0];
                        mvt_pkg::DST_DET: det_reg <= sacc_new;
                        default:          det_reg <= det_reg;
                    endcase
                end
            end
            mvt_pkg::ST_DWAIT:
            begin
                if (div_done)
                begin
                    pos_reg[n_reg] <= div_q;
                end
            end
            mvt_pkg::ST_EMIT:
            begin
                if (sing_reg)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        pos_reg[i] <= '0;
                    end
                end
            end
            default:
            begin
                p2_reg <= p2_reg;
            end
        endcase
    end

    assign pos_x = pos_reg[0];
    assign pos_y = pos_reg[1];
    assign pos_z = pos_reg[2];
    assign singular = sing_reg;
    assign done = done_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");

    a_cleared_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (view_reg == 4'd0 && acc_reg[0] == '0 && acc_reg[8] == '0))
        else $error("accumulators not cleared after a result");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && sing_reg) |-> (pos_reg[0] == '0 && pos_reg[1] == '0 && pos_reg[2] == '0))
        else $error("singular result with nonzero position");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == mvt_pkg::ST_IDLE))
        else $error("queue popped while a word is in progress");

endmodule
`default_nettype wire

[hdl/multiview_point_triangulation.sv]
// Top level of the linear multi-view point triangulation block.
//
//  channel | ports                                          | handshake
//  --------+------------------------------------------------+------------------------
//  command | cmd camera coef_index coef_value obs_x obs_y   | start & !busy
//          | last_obs                                       |
//  result  | pos_x pos_y pos_z singular                     | done, one cycle
//  config  | focal_scale                                    | focal_scale_we
//
//  A coefficient write is stored straight from the queue in the back end; an observation
//  computes 8 row terms and 18 products. A final observation adds the solve: a scaling
//  step that halves all sums until they fit, 24 multiplier passes and 3 divisions.
//  A two-word queue lets commands land while the back end works; busy rises when full.
//  Reset clears the accumulators, view count and queue; the coefficient store is not
//  cleared. Results cannot be stalled.
`default_nettype none
module multiview_point_triangulation #(
    parameter int CAMERAS = mvt_pkg::CAMERAS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               cmd,
    input  wire logic [2:0]         camera,
    input  wire logic [3:0]         coef_index,
    input  wire logic signed [47:0] coef_value,
    input  wire logic [19:0]        obs_x,
    input  wire logic [19:0]        obs_y,
    input  wire logic               last_obs,
    input  wire logic               focal_scale_we,
    input  wire logic [11:0]        focal_scale,
    output logic                    done,
    output logic signed [47:0]      pos_x,
    output logic signed [47:0]      pos_y,
    output logic signed [47:0]      pos_z,
    output logic                    singular
);

    logic [11:0]     focal_reg;
    mvt_pkg::qword_t q_word;
    logic            q_valid, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg <= mvt_pkg::FOCAL_RESET;
        end
        else if (focal_scale_we)
        begin
            focal_reg <= focal_scale;
        end
    end

    mvt_front #(.CAMERAS(CAMERAS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .camera     (camera),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .obs_x      (obs_x),
        .obs_y      (obs_y),
        .last_obs   (last_obs),
        .busy       (busy),
        .q_word     (q_word),
        .q_valid    (q_valid),
        .q_pop      (q_pop)
    );

    mvt_back #(.CAMERAS(CAMERAS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .focal_scale (focal_reg),
        .q_word      (q_word),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .singular    (singular),
        .done        (done)
    );

endmodule
`default_nettype wire

[sim/multiview_point_triangulation_tb.sv]
// Self-checking testbench for the multi-view point triangulation block.
`default_nettype none
module multiview_point_triangulation_tb;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [63:0]  acc_t;

    typedef struct {
        logic               cmd;
        logic [2:0]         camera;
        logic [3:0]         coef_index;
        logic signed [47:0] coef_value;
        logic [19:0]        obs_x;
        logic [19:0]        obs_y;
        logic               last_obs;
    } word_t;

    typedef struct {
        logic signed [47:0] x;
        logic signed [47:0] y;
        logic signed [47:0] z;
        logic               singular;
    } point_t;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_OBS   = 1'b1;
    localparam wide_t S64_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam wide_t S64_MIN = -S64_MAX - 1;
    localparam wide_t LIM30 = 128'sd1073741824;
    localparam logic [127:0] POS_MAX = 128'h7FFF_FFFF_FFFF;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE = 900;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               cmd = 1'b0;
    logic [2:0]         camera = '0;
    logic [3:0]         coef_index = '0;
    logic signed [47:0] coef_value = '0;
    logic [19:0]        obs_x = '0;
    logic [19:0]        obs_y = '0;
    logic               last_obs = 1'b0;
    logic               focal_scale_we = 1'b0;
    logic [11:0]        focal_scale = mvt_pkg::FOCAL_RESET;
    logic               done;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [47:0] pos_z;
    logic               singular;

    multiview_point_triangulation dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .camera(camera), .coef_index(coef_index), .coef_value(coef_value),
        .obs_x(obs_x), .obs_y(obs_y), .last_obs(last_obs),
        .focal_scale_we(focal_scale_we), .focal_scale(focal_scale),
        .done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .singular(singular)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic signed [47:0] proj [mvt_pkg::CAMERAS_DEF][mvt_pkg::COEFS];
    acc_t               normal_acc [6];
    acc_t               rhs_acc [3];
    int unsigned        views;
    logic [11:0]        focal;

    word_t  pending_words [$];
    point_t expected_points [$];
    logic [11:0] loaded [mvt_pkg::CAMERAS_DEF];
    int errors = 0;
    int words_sent = 0;
    int points_seen = 0;
    int singular_seen = 0;
    int idle_cycles = 0;

    function automatic acc_t sat64(input wide_t v);
        if (v > S64_MAX) return S64_MAX[63:0];
        if (v < S64_MIN) return S64_MIN[63:0];
        return v[63:0];
    endfunction

    function automatic wide_t row_term(input logic signed [47:0] pr,
                                       input logic signed [47:0] p2, input logic [19:0] w);
        wide_t a, b, ww, f;
        a = pr;
        b = p2;
        ww = w;
        f = focal;
        return f * a - ((b * ww) >>> 8);
    endfunction

    function automatic acc_t prod_q16(input wide_t a, input wide_t b);
        wide_t p;
        p = (a * b) >>> 32;
        return sat64(p);
    endfunction

    function automatic logic signed [47:0] ratio_q16(input wide_t num, input wide_t den);
        logic [127:0] n, d, q, lim;
        logic neg;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = ((n << 17) + d) / (d << 1);
        lim = neg ? POS_MAX + 1 : POS_MAX;
        if (q > lim) q = lim;
        if (neg) q = -q;
        return q[47:0];
    endfunction

    task automatic add_views(input logic [2:0] cam, input logic [19:0] ox,
                             input logic [19:0] oy);
        wide_t t [4];
        logic [19:0] w;
        for (int r = 0; r < 2; r++)
        begin
            w = r ? oy : ox;
            for (int j = 0; j < 4; j++)
                t[j] = row_term(proj[cam][4*r+j], proj[cam][8+j], w);
            normal_acc[0] = sat64(wide_t'(normal_acc[0]) + prod_q16(t[0], t[0]));
            normal_acc[1] = sat64(wide_t'(normal_acc[1]) + prod_q16(t[0], t[1]));
            normal_acc[2] = sat64(wide_t'(normal_acc[2]) + prod_q16(t[0], t[2]));
            normal_acc[3] = sat64(wide_t'(normal_acc[3]) + prod_q16(t[1], t[1]));
            normal_acc[4] = sat64(wide_t'(normal_acc[4]) + prod_q16(t[1], t[2]));
            normal_acc[5] = sat64(wide_t'(normal_acc[5]) + prod_q16(t[2], t[2]));
            for (int j = 0; j < 3; j++)
                rhs_acc[j] = sat64(wide_t'(rhs_acc[j]) - prod_q16(t[j], t[3]));
        end
    endtask

    function automatic point_t solve_point();
        point_t p;
        wide_t v [9];
        wide_t c00, c01, c02, c11, c12, c22, det;
        bit fits;
        p = '{x: '0, y: '0, z: '0, singular: 1'b1};
        if (views < mvt_pkg::VIEW_MIN) return p;
        for (int s = 0; s <= 33; s++)
        begin
            fits = 1'b1;
            for (int k = 0; k < 9; k++)
            begin
                v[k] = (k < 6) ? wide_t'(normal_acc[k]) >>> s : wide_t'(rhs_acc[k-6]) >>> s;
                if (v[k] < -LIM30 || v[k] > LIM30 - 1) fits = 1'b0;
            end
            if (fits) break;
        end
        c00 = v[3]*v[5] - v[4]*v[4];
        c01 = v[2]*v[4] - v[1]*v[5];
        c02 = v[1]*v[4] - v[3]*v[2];
        c11 = v[0]*v[5] - v[2]*v[2];
        c12 = v[1]*v[2] - v[0]*v[4];
        c22 = v[0]*v[3] - v[1]*v[1];
        det = v[0]*c00 + v[1]*c01 + v[2]*c02;
        if (det == 0) return p;
        p.x = ratio_q16(c00*v[6] + c01*v[7] + c02*v[8], det);
        p.y = ratio_q16(c01*v[6] + c11*v[7] + c12*v[8], det);
        p.z = ratio_q16(c02*v[6] + c12*v[7] + c22*v[8], det);
        p.singular = 1'b0;
        return p;
    endfunction

    task automatic predict_word(input word_t wd);
        if (wd.cmd == CMD_WRITE)
        begin
            if (wd.coef_index < mvt_pkg::COEFS) proj[wd.camera][wd.coef_index] = wd.coef_value;
            return;
        end
        add_views(wd.camera, wd.obs_x, wd.obs_y);
        if (views < mvt_pkg::VIEW_MAX) views++;
        if (!wd.last_obs) return;
        expected_points.push_back(solve_point());
        foreach (normal_acc[k]) normal_acc[k] = '0;
        foreach (rhs_acc[k]) rhs_acc[k] = '0;
        views = 0;
    endtask

    task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // driver: bursts of words with random gaps
    int burst_left = 1;
    int gap_left = 0;
    always @(posedge clk)
    begin
        word_t wd;
        logic accepted;
        accepted = start && !busy;
        if (accepted)
        begin
            wd = '{cmd, camera, coef_index, coef_value, obs_x, obs_y, last_obs};
            predict_word(wd);
            words_sent++;
        end
        if (rst_n && (!start || accepted))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                wd = pending_words.pop_front();
                start <= 1'b1;
                cmd <= wd.cmd;
                camera <= wd.camera;
                coef_index <= wd.coef_index;
                coef_value <= wd.coef_value;
                obs_x <= wd.obs_x;
                obs_y <= wd.obs_y;
                last_obs <= wd.last_obs;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        point_t e;
        if (rst_n && done)
        begin
            if (expected_points.size() == 0)
            begin
                $display("unexpected result word");
                errors++;
            end
            else
            begin
                e = expected_points.pop_front();
                points_seen++;
                if (singular) singular_seen++;
                if (pos_x !== e.x) report("pos_x", pos_x, e.x);
                if (pos_y !== e.y) report("pos_y", pos_y, e.y);
                if (pos_z !== e.z) report("pos_z", pos_z, e.z);
                if (singular !== e.singular) report("singular", 48'(singular), 48'(e.singular));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired");
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_word(input logic c, input logic [2:0] cam, input logic [3:0] idx,
                             input logic signed [47:0] val, input logic [19:0] ox,
                             input logic [19:0] oy, input logic last);
        pending_words.push_back('{c, cam, idx, val, ox, oy, last});
        if (c == CMD_WRITE && idx < mvt_pkg::COEFS) loaded[cam][idx] = 1'b1;
    endtask

    function automatic logic signed [47:0] rand_coef();
        logic signed [47:0] r;
        r = 48'({$urandom, $urandom});
        if ($urandom_range(0, 3) != 0) r = r >>> $urandom_range(8, 40);
        return r;
    endfunction

    function automatic logic [19:0] rand_pixel();
        if ($urandom_range(0, 3) == 0) return 20'($urandom);
        return 20'($urandom_range(0, 4095));
    endfunction

    function automatic logic [2:0] ready_camera();
        logic [2:0] c;
        for (int k = 0; k < 20; k++)
        begin
            c = 3'($urandom_range(0, mvt_pkg::CAMERAS_DEF - 1));
            if (loaded[c] == 12'hFFF) return c;
        end
        return 3'd0;
    endfunction

    task automatic push_point();
        int nviews;
        logic [2:0] c;
        if ($urandom_range(0, 7) == 0)
        begin
            c = 3'($urandom_range(0, mvt_pkg::CAMERAS_DEF - 1));
            for (int i = 0; i < mvt_pkg::COEFS; i++)
                push_word(CMD_WRITE, c, 4'(i), rand_coef(), 20'd0, 20'd0, 1'b0);
        end
        repeat ($urandom_range(0, 3))
            push_word(CMD_WRITE, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                      rand_coef(), 20'($urandom), 20'($urandom), 1'($urandom_range(0, 1)));
        nviews = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 5);
        for (int i = 0; i < nviews; i++)
            push_word(CMD_OBS, ready_camera(), 4'($urandom_range(0, 15)), rand_coef(),
                      rand_pixel(), rand_pixel(), i == nviews - 1);
    endtask

    task automatic settle_and_set_focal(input logic [11:0] f);
        while (pending_words.size() > 0 || start || expected_points.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        focal_scale_we <= 1'b1;
        focal_scale <= f;
        focal = f;
        @(posedge clk);
        focal_scale_we <= 1'b0;
    endtask

    localparam logic signed [47:0] ONE = 48'sd1 << 24;

    initial
    begin
        logic [11:0] focal_plan [5];
        foreach (normal_acc[k]) normal_acc[k] = '0;
        foreach (rhs_acc[k]) rhs_acc[k] = '0;
        foreach (loaded[k]) loaded[k] = '0;
        views = 0;
        focal = mvt_pkg::FOCAL_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        settle_and_set_focal(12'd1);

        // two simple cameras, the second shifted along x
        for (int c = 0; c < 2; c++)
            for (int i = 0; i < mvt_pkg::COEFS; i++)
                push_word(CMD_WRITE, 3'(c), 4'(i),
                          (i == 0 || i == 5 || i == 10) ? ONE :
                          (i == 11) ? 4 * ONE : (i == 3 && c == 1) ? -ONE : 48'sd0,
                          20'd0, 20'd0, 1'b0);
        push_word(CMD_OBS, 3'd0, 4'd0, 48'sd0, 20'd256, 20'd512, 1'b1);
        push_word(CMD_OBS, 3'd0, 4'd0, 48'sd0, 20'd256, 20'd512, 1'b0);
        push_word(CMD_OBS, 3'd1, 4'd0, 48'sd0, 20'd0, 20'hFFFFF, 1'b1);
        push_word(CMD_OBS, 3'd0, 4'd0, 48'sd0, 20'd128, 20'd128, 1'b0);
        push_word(CMD_OBS, 3'd0, 4'd0, 48'sd0, 20'd128, 20'd128, 1'b1);
        push_word(CMD_WRITE, 3'd7, 4'd15, 48'sh7FFF_FFFF_FFFF, 20'd0, 20'd0, 1'b1);
        push_word(CMD_WRITE, 3'd7, 4'd0, 48'sh8000_0000_0000, 20'hFFFFF, 20'hFFFFF, 1'b1);
        push_word(CMD_OBS, 3'd1, 4'd0, 48'sd0, 20'hFFFFF, 20'hFFFFF, 1'b0);
        push_word(CMD_OBS, 3'd0, 4'd0, 48'sd0, 20'hFFFFF, 20'd0, 1'b1);

        focal_plan = '{12'd1, 12'd4095, 12'd0, 12'($urandom_range(2, 4094)),
                       12'($urandom_range(1, 64))};
        foreach (focal_plan[p])
        begin
            settle_and_set_focal(focal_plan[p]);
            for (int n = pending_words.size(); n < 80; n = pending_words.size())
                push_point();
        end

        while (pending_words.size() > 0 || start || expected_points.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        $display("words sent %0d, points solved %0d (%0d singular), 6 focal settings",
                 words_sent, points_seen, singular_seen);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
hdl/mvt_pkg.sv
hdl/mvt_ram.sv
hdl/mvt_mul.sv
hdl/mvt_div.sv
hdl/mvt_front.sv
hdl/mvt_back.sv
hdl/multiview_point_triangulation.sv
sim/multiview_point_triangulation_tb.sv
